/* design/chol_pkg.sv */
// Shared types, constants and index helper for the Cholesky factor block.
`default_nettype none
package chol_pkg;

	localparam int DIM_DEF       = 6;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IDX_W         = 3;
	// Wide enough for the triangle position at the largest supported dimension.
	localparam int POS_W         = 6;
	localparam int VAL_W         = 32;
	localparam int ACC_W         = 64;
	localparam int CNT_W         = 6;

	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] cov_value;
		logic                    load_last;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_row;
		logic [IDX_W-1:0]        out_col;
		logic signed [VAL_W-1:0] factor_value;
		logic                    not_positive;
		logic                    out_last;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_ACC_CLR,
		OP_DOT_RA,
		OP_DOT_RB,
		OP_DOT_MUL,
		OP_DOT_ACC,
		OP_COV_RD,
		OP_WIDE,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_RESULT,
		OP_WRITE,
		OP_EMIT_RD,
		OP_OUT_LOAD
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_ENTRY,
		ST_DOT_RA,
		ST_DOT_RB,
		ST_DOT_MUL,
		ST_DOT_ACC,
		ST_COV_RD,
		ST_WIDE,
		ST_DECIDE,
		ST_SQRT,
		ST_DIV,
		ST_RESULT,
		ST_WRITE,
		ST_EMIT_RD,
		ST_EMIT_WAIT,
		ST_EMIT_OUT
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t           op;
		logic             load;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
		logic [IDX_W-1:0] k;
		logic [POS_W-1:0] pos;
		logic             diag;
		logic             zero;
		logic             not_pos;
		logic             last;
	} dp_cmd_t;

	typedef struct packed {
		logic wide_le0;
		logic d_le0;
		logic res_nz;
	} dp_status_t;

	// Position of (r, c) in the row-ordered lower triangle.
	function automatic logic [POS_W-1:0] tri_pos(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		logic [2*IDX_W:0] p;
		begin
			p = {{(IDX_W+1){1'b0}}, r} * ({{(IDX_W+1){1'b0}}, r} + 1'b1);
			tri_pos = POS_W'(p >> 1) + POS_W'(c);
		end
	endfunction

endpackage
`default_nettype wire

/* design/chol_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module chol_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 21,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* design/chol_ctrl.sv */
// Sequencer that walks the factorization and emission loops of the Cholesky block.
`default_nettype none
module chol_ctrl #(
	parameter int DIM = chol_pkg::DIM_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                load_last,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output chol_pkg::dp_cmd_t        cmd,
	input  wire chol_pkg::dp_status_t status
);
	import chol_pkg::*;

	localparam int TRI = DIM * (DIM + 1) / 2;

	ctrl_state_t      state_q, state_d;
	logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [POS_W-1:0] pos_q, pos_d, fail_q, fail_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             err_q, err_d;
	logic             diag;
	logic             row_end;
	logic             last_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			pos_q   <= '0;
			fail_q  <= '0;
			cnt_q   <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			pos_q   <= pos_d;
			fail_q  <= fail_d;
			cnt_q   <= cnt_d;
			err_q   <= err_d;
		end
	end

	assign diag     = (i_q == j_q);
	assign row_end  = (i_q == IDX_W'(DIM - 1));
	assign last_pos = (pos_q == POS_W'(TRI - 1));

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		pos_d   = pos_q;
		fail_d  = fail_q;
		cnt_d   = cnt_q;
		err_d   = err_q;

		in_ready  = 1'b0;
		out_valid = 1'b0;

		cmd.op      = OP_NONE;
		cmd.load    = 1'b0;
		cmd.i       = i_q;
		cmd.j       = j_q;
		cmd.k       = k_q;
		cmd.pos     = pos_q;
		cmd.diag    = diag;
		cmd.zero    = err_q;
		// Flagged from just past the last non-zero entry once a radicand has failed.
		cmd.not_pos = err_q && (pos_q >= fail_q);
		cmd.last    = last_pos;

		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && load_last) begin
					err_d   = 1'b0;
					fail_d  = '0;
					i_d     = '0;
					j_d     = '0;
					pos_d   = '0;
					state_d = ST_ENTRY;
				end
			end
			ST_ENTRY: begin
				cmd.op = OP_ACC_CLR;
				k_d    = '0;
				state_d = (j_q == '0) ? ST_COV_RD : ST_DOT_RA;
			end
			ST_DOT_RA: begin
				cmd.op  = OP_DOT_RA;
				state_d = ST_DOT_RB;
			end
			ST_DOT_RB: begin
				cmd.op  = OP_DOT_RB;
				state_d = ST_DOT_MUL;
			end
			ST_DOT_MUL: begin
				cmd.op  = OP_DOT_MUL;
				state_d = ST_DOT_ACC;
			end
			ST_DOT_ACC: begin
				cmd.op = OP_DOT_ACC;
				k_d    = k_q + 1'b1;
				state_d = ((k_q + 1'b1) == j_q) ? ST_COV_RD : ST_DOT_RA;
			end
			ST_COV_RD: begin
				cmd.op  = OP_COV_RD;
				state_d = ST_WIDE;
			end
			ST_WIDE: begin
				cmd.op  = OP_WIDE;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cnt_d = '0;
				priority if (err_q) begin
					state_d = ST_WRITE;
				end else if (diag) begin
					if (status.wide_le0) begin
						err_d   = 1'b1;
						state_d = ST_WRITE;
					end else begin
						cmd.op  = OP_SQRT_INIT;
						state_d = ST_SQRT;
					end
				end else begin
					if (status.d_le0) begin
						err_d   = 1'b1;
						state_d = ST_WRITE;
					end else begin
						cmd.op  = OP_DIV_INIT;
						state_d = ST_DIV;
					end
				end
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(VAL_W - 1)) begin
					state_d = ST_RESULT;
				end
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ACC_W - 1)) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				cmd.op  = OP_RESULT;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.op = OP_WRITE;
				if (!err_q && status.res_nz) begin
					fail_d = pos_q + 1'b1;
				end
				pos_d = pos_q + 1'b1;
				if (diag) begin
					j_d = '0;
					if (row_end) begin
						i_d     = '0;
						pos_d   = '0;
						state_d = ST_EMIT_RD;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = ST_ENTRY;
					end
				end else begin
					j_d     = j_q + 1'b1;
					state_d = ST_ENTRY;
				end
			end
			ST_EMIT_RD: begin
				cmd.op  = OP_EMIT_RD;
				state_d = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				cmd.op  = OP_OUT_LOAD;
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (last_pos) begin
						state_d = ST_LOAD;
					end else begin
						pos_d = pos_q + 1'b1;
						if (diag) begin
							j_d = '0;
							i_d = i_q + 1'b1;
						end else begin
							j_d = j_q + 1'b1;
						end
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule
`default_nettype wire

/* design/chol_dp.sv */
// Datapath: entry stores, dot-product accumulator, square-root and divider units.
`default_nettype none
module chol_dp #(
	parameter int DIM       = chol_pkg::DIM_DEF,
	parameter int FRAC_BITS = chol_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire chol_pkg::in_item_t in_data,
	input  wire chol_pkg::dp_cmd_t  cmd,
	output chol_pkg::dp_status_t    status,
	output chol_pkg::out_item_t     out_data
);
	import chol_pkg::*;

	localparam int TRI = DIM * (DIM + 1) / 2;
	localparam int AW  = $clog2(TRI);

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	// Magnitude of the most negative 32-bit value, zero-extended to the quotient width.
	localparam logic [ACC_W-1:0] NEG_LIMIT = {{(ACC_W-VAL_W){1'b0}}, 1'b1, {(VAL_W-1){1'b0}}};

	logic                    cov_we;
	logic [AW-1:0]           cov_waddr, cov_raddr;
	logic signed [VAL_W-1:0] cov_rd;
	logic                    fac_we;
	logic [AW-1:0]           fac_raddr;
	logic signed [VAL_W-1:0] fac_rd, fac_wdata;

	logic signed [VAL_W-1:0] a_q, d_q, res_q;
	logic signed [ACC_W-1:0] prod_q, acc_q, wide_q;
	logic signed [ACC_W:0]   acc_sum, wide_diff;
	logic signed [ACC_W-1:0] cov_scaled;
	out_item_t               out_q;

	logic [ACC_W-1:0]  sq_x_q;
	logic [VAL_W:0]    sq_rem_q;
	logic [VAL_W-1:0]  sq_root_q;
	logic [VAL_W+2:0]  sq_t, sq_trial;

	logic [ACC_W-1:0]  dv_q_q;
	logic [VAL_W-1:0]  dv_rem_q;
	logic [VAL_W:0]    dv_t;
	logic              dv_neg_q;
	logic [ACC_W-1:0]  wide_mag;
	logic signed [VAL_W-1:0] div_sat, sqrt_sat;

	// Only lower-triangle entries inside the matrix are stored.
	assign cov_we = cmd.load
		&& ({1'b0, in_data.row} < (IDX_W+1)'(DIM))
		&& (in_data.col <= in_data.row);
	assign cov_waddr = AW'(tri_pos(in_data.row, in_data.col));
	assign cov_raddr = AW'(tri_pos(cmd.i, cmd.j));

	always_comb begin
		unique case (cmd.op)
			OP_DOT_RA:  fac_raddr = AW'(tri_pos(cmd.i, cmd.k));
			OP_DOT_RB:  fac_raddr = AW'(tri_pos(cmd.j, cmd.k));
			OP_COV_RD:  fac_raddr = AW'(tri_pos(cmd.j, cmd.j));
			default:    fac_raddr = cmd.pos[AW-1:0];
		endcase
	end

	assign fac_we    = (cmd.op == OP_WRITE);
	assign fac_wdata = cmd.zero ? '0 : res_q;

	chol_ram #(.WIDTH(VAL_W), .DEPTH(TRI)) u_cov_ram (
		.clk   (clk),
		.we    (cov_we),
		.waddr (cov_waddr),
		.wdata (in_data.cov_value),
		.raddr (cov_raddr),
		.rdata (cov_rd)
	);

	chol_ram #(.WIDTH(VAL_W), .DEPTH(TRI)) u_fac_ram (
		.clk   (clk),
		.we    (fac_we),
		.waddr (cmd.pos[AW-1:0]),
		.wdata (fac_wdata),
		.raddr (fac_raddr),
		.rdata (fac_rd)
	);

	assign acc_sum    = {acc_q[ACC_W-1], acc_q} + {prod_q[ACC_W-1], prod_q};
	assign cov_scaled = ACC_W'(cov_rd) <<< FRAC_BITS;
	assign wide_diff  = {cov_scaled[ACC_W-1], cov_scaled} - {acc_q[ACC_W-1], acc_q};

	// Square root: two radicand bits per step, one root bit out.
	assign sq_t     = {sq_rem_q, sq_x_q[ACC_W-1 -: 2]};
	assign sq_trial = {1'b0, sq_root_q, 2'b01};
	assign sqrt_sat = sq_root_q[VAL_W-1] ? VAL_MAX : $signed(sq_root_q);

	// Restoring divider on the magnitude; the sign is put back at the end.
	assign wide_mag = wide_q[ACC_W-1] ? (~wide_q + 1'b1) : wide_q;
	assign dv_t     = {dv_rem_q, dv_q_q[ACC_W-1]};

	always_comb begin
		if (dv_neg_q) begin
			if (dv_q_q > NEG_LIMIT) begin
				div_sat = VAL_MIN;
			end else begin
				div_sat = VAL_W'(~dv_q_q + 1'b1);
			end
		end else if (dv_q_q > ACC_W'(VAL_MAX)) begin
			div_sat = VAL_MAX;
		end else begin
			div_sat = VAL_W'(dv_q_q);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ACC_CLR: acc_q <= '0;
			OP_DOT_RB:  a_q <= fac_rd;
			OP_DOT_MUL: prod_q <= ACC_W'(a_q) * ACC_W'(fac_rd);
			OP_DOT_ACC: begin
				if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
					acc_q <= acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
				end else begin
					acc_q <= acc_sum[ACC_W-1:0];
				end
			end
			OP_WIDE: begin
				d_q <= fac_rd;
				if (wide_diff[ACC_W] != wide_diff[ACC_W-1]) begin
					wide_q <= wide_diff[ACC_W] ? ACC_MIN : ACC_MAX;
				end else begin
					wide_q <= wide_diff[ACC_W-1:0];
				end
			end
			OP_SQRT_INIT: begin
				sq_x_q    <= wide_q;
				sq_rem_q  <= '0;
				sq_root_q <= '0;
			end
			OP_SQRT_STEP: begin
				sq_x_q <= sq_x_q << 2;
				if (sq_t >= sq_trial) begin
					sq_rem_q  <= (VAL_W+1)'(sq_t - sq_trial);
					sq_root_q <= {sq_root_q[VAL_W-2:0], 1'b1};
				end else begin
					sq_rem_q  <= (VAL_W+1)'(sq_t);
					sq_root_q <= {sq_root_q[VAL_W-2:0], 1'b0};
				end
			end
			OP_DIV_INIT: begin
				dv_q_q   <= wide_mag;
				dv_rem_q <= '0;
				dv_neg_q <= wide_q[ACC_W-1];
			end
			OP_DIV_STEP: begin
				if (dv_t >= {1'b0, d_q}) begin
					dv_rem_q <= VAL_W'(dv_t - {1'b0, d_q});
					dv_q_q   <= {dv_q_q[ACC_W-2:0], 1'b1};
				end else begin
					dv_rem_q <= dv_t[VAL_W-1:0];
					dv_q_q   <= {dv_q_q[ACC_W-2:0], 1'b0};
				end
			end
			OP_RESULT:  res_q <= cmd.diag ? sqrt_sat : div_sat;
			OP_OUT_LOAD: begin
				out_q.out_row      <= cmd.i;
				out_q.out_col      <= cmd.j;
				out_q.factor_value <= fac_rd;
				out_q.not_positive <= cmd.not_pos;
				out_q.out_last     <= cmd.last;
			end
			default: begin
			end
		endcase
	end

	assign status.wide_le0 = (wide_q <= 0);
	assign status.d_le0    = (d_q <= 0);
	assign status.res_nz   = (res_q != '0);
	assign out_data        = out_q;

endmodule
`default_nettype wire

/* design/cholesky_factor_6x6_top.sv */
// Top level of the Cholesky factorization block for a symmetric DIM x DIM matrix.
// Lower-triangle entries are loaded one beat per cycle; upper-triangle and out-of-range
// beats are dropped. The beat with load_last set starts the factorization, during
// which no input is taken. Each factor entry at row i, column j runs a dot product over
// j terms, then (unless failed) 32 square-root steps on the diagonal or 64 divider steps.
// The 21 entries then leave in row order, each read from the factor store and
// registered before it is offered; the next is read only once the receiver takes it. A
// matrix that is not positive definite yields zeros with not_positive set from just
// past the last non-zero factor entry. Stored entries persist across factorizations.
`default_nettype none
module cholesky_factor_6x6_top #(
	parameter int DIM       = chol_pkg::DIM_DEF,
	parameter int FRAC_BITS = chol_pkg::FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire chol_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output chol_pkg::out_item_t      out_data
);
	import chol_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	chol_ctrl #(.DIM(DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.load_last (in_data.load_last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	chol_dp #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk      (clk),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

/* tb/tb_cholesky_factor_6x6_top.sv */
// Self-checking testbench for the 6x6 Cholesky factor block.
`default_nettype none
module tb_cholesky_factor_6x6_top;
	timeunit 1ns;
	timeprecision 1ps;
	import chol_pkg::*;

	localparam int N       = 6;
	localparam int FRAC    = 16;
	localparam int TRI     = N * (N + 1) / 2;
	localparam int N_ITEMS = 450;
	localparam int STALL   = 17;
	localparam int HOLDOFF = 3000;
	localparam int IDLE_LIMIT = 20000;

	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_ZERO_FAIL,
		CHK_UNIT
	} chk_t;

	typedef struct packed {
		in_item_t beat;
		chk_t     chk;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	cholesky_factor_6x6_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Predictor state.
	logic signed [31:0] cov_mem [TRI];
	longint             fac_mem [TRI];
	out_item_t          factor_q[$];

	int n_errors;
	int n_items;
	int n_results;
	int n_factorizations;
	int n_flagged;
	bit pressure_done;
	bit sender_burst;
	bit receiver_burst;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int lower_pos(input int r, input int c);
		return r * (r + 1) / 2 + c;
	endfunction

	function automatic longint clamp64(input logic signed [64:0] s);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_8000_0000_0000_0000)
			return 64'sh8000_0000_0000_0000;
		return longint'(s);
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned x);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Stores the beat and, on load_last, queues all factor entries in row order.
	task automatic cholesky_predict(input in_item_t it, input chk_t chk);
		bit        broken;
		bit        flagged;
		bit        later_nz;
		longint    acc;
		longint    wide;
		longint    val;
		longint    d;
		out_item_t o;
		int        n;
		if (it.row < N && it.col <= it.row)
			cov_mem[lower_pos(it.row, it.col)] = it.cov_value;
		if (!it.load_last)
			return;
		n_factorizations++;
		broken = 1'b0;
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j <= i; j++) begin
				acc = 0;
				val = 0;
				for (int k = 0; k < j; k++)
					acc = clamp64(65'(acc) + 65'(fac_mem[lower_pos(i, k)] *
						fac_mem[lower_pos(j, k)]));
				wide = clamp64(65'(longint'(cov_mem[lower_pos(i, j)]) * (64'sd1 <<< FRAC))
					- 65'(acc));
				if (!broken) begin
					if (i == j) begin
						if (wide <= 0)
							broken = 1'b1;
						else
							val = clamp32(longint'(root_floor(longint'(wide))));
					end else begin
						d = fac_mem[lower_pos(j, j)];
						if (d > 0)
							val = clamp32(wide / d);
						else
							broken = 1'b1;
					end
				end
				fac_mem[lower_pos(i, j)] = broken ? 0 : val;
			end
		end
		// The flag rises on the first zero entry past which nothing non-zero remains.
		flagged = 1'b0;
		n = 0;
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j <= i; j++) begin
				if (broken && fac_mem[lower_pos(i, j)] == 0 && !flagged) begin
					later_nz = 1'b0;
					for (int p = lower_pos(i, j); p < TRI; p++)
						if (fac_mem[p] != 0)
							later_nz = 1'b1;
					flagged = !later_nz;
				end
				o.out_row      = IDX_W'(i);
				o.out_col      = IDX_W'(j);
				o.factor_value = VAL_W'(fac_mem[lower_pos(i, j)]);
				o.not_positive = flagged;
				o.out_last     = (n == TRI - 1);
				case (chk)
					CHK_ZERO_FAIL: begin
						o.factor_value = '0;
						o.not_positive = 1'b1;
					end
					CHK_UNIT: begin
						o.factor_value = (i == j) ? 32'sd65536 : 32'sd0;
						o.not_positive = 1'b0;
					end
					default: ;
				endcase
				factor_q.push_back(o);
				n++;
			end
		end
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
		n_errors++;
	endtask

	// Offers one beat, after a random gap unless the sender is in burst mode, and returns once it has been accepted.
	task automatic send_beat(input in_item_t it, input chk_t chk);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, STALL);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		cholesky_predict(it, chk);
		if (it.row < N && it.col <= it.row)
			n_items++;
	endtask

	function automatic in_item_t mk(input int r, input int c, input int v, input bit last);
		in_item_t it;
		it.row       = IDX_W'(r);
		it.col       = IDX_W'(c);
		it.cov_value = v;
		it.load_last = last;
		return it;
	endfunction

	task automatic send_noise();
		int r;
		int c;
		r = $urandom_range(0, 7);
		c = $urandom_range(0, 7);
		if (r < N && c <= r)
			r = N + $urandom_range(0, 1);
		send_beat(mk(r, c, $urandom, ($urandom_range(0, 9) == 0)), CHK_PREDICT);
	endtask

	// Diagonally dominant random matrix, positive definite unless one diagonal is made non-positive.
	task automatic send_good_matrix();
		int base;
		int bad_row;
		int v;
		case ($urandom_range(0, 19))
			0:       base = 32'h6000_0000;
			1:       base = $urandom_range(1, 64);
			default: base = $urandom_range(1 << 12, 1 << 28);
		endcase
		bad_row = ($urandom_range(0, 5) == 0) ? $urandom_range(0, N - 1) : -1;
		for (int r = 0; r < N; r++) begin
			for (int c = 0; c <= r; c++) begin
				if (r == c)
					v = (r == bad_row) ? -$urandom_range(0, base) :
						base + $urandom_range(0, base / 4);
				else
					v = $urandom_range(0, base / 4) - base / 8;
				if ($urandom_range(0, 9) == 0)
					send_noise();
				send_beat(mk(r, c, v, (r == N - 1 && c == r)), CHK_PREDICT);
			end
		end
	endtask

	task automatic send_partial();
		int cnt;
		int r;
		cnt = $urandom_range(1, 5);
		for (int n = 0; n < cnt; n++) begin
			r = $urandom_range(0, N - 1);
			send_beat(mk(r, $urandom_range(0, r), $urandom, (n == cnt - 1)), CHK_PREDICT);
		end
	endtask

	// Receiver: random stalls, one long hold-off once the block has produced results.
	initial begin
		int stall;
		out_item_t want;
		@(posedge arst_n);
		forever begin
			if (!pressure_done && n_results >= 100) begin
				out_ready <= 1'b0;
				repeat (HOLDOFF) @(posedge clk);
				pressure_done = 1'b1;
			end else begin
				stall = receiver_burst ? 0 : $urandom_range(0, STALL);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			n_results++;
			if (factor_q.size() == 0) begin
				$display("UNEXPECTED result row %0d col %0d value %0d",
					out_data.out_row, out_data.out_col, out_data.factor_value);
				n_errors++;
			end else begin
				want = factor_q.pop_front();
				if (out_data.out_row !== want.out_row)
					report("out_row", out_data.out_row, want.out_row);
				if (out_data.out_col !== want.out_col)
					report("out_col", out_data.out_col, want.out_col);
				if (out_data.factor_value !== want.factor_value)
					report("factor_value", out_data.factor_value, want.factor_value);
				if (out_data.not_positive !== want.not_positive)
					report("not_positive", out_data.not_positive, want.not_positive);
				if (out_data.out_last !== want.out_last)
					report("out_last", out_data.out_last, want.out_last);
				if (out_data.not_positive === 1'b1)
					n_flagged++;
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a beat.
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("watchdog expired after %0d idle cycles", idle);
				$display("cholesky_factor_6x6_top test failed");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t dir_rows[$];
		int tail;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		n_errors  = 0;
		n_items   = 0;
		n_results = 0;
		n_factorizations = 0;
		n_flagged = 0;
		pressure_done  = 1'b0;
		sender_burst   = 1'b0;
		receiver_burst = 1'b0;
		for (int p = 0; p < TRI; p++) begin
			cov_mem[p] = '0;
			fac_mem[p] = 0;
		end

		// All-zero matrix fails on the first diagonal, then the unit matrix.
		for (int r = 0; r < N; r++)
			for (int c = 0; c <= r; c++)
				dir_rows.push_back('{mk(r, c, 0, (r == N - 1 && c == r)),
					(r == N - 1 && c == r) ? CHK_ZERO_FAIL : CHK_PREDICT});
		for (int r = 0; r < N; r++)
			dir_rows.push_back('{mk(r, r, 32'sd65536, (r == N - 1)),
				(r == N - 1) ? CHK_UNIT : CHK_PREDICT});
		// Upper-triangle and out-of-range beats must leave the store alone; then extreme values on the first diagonal.
		dir_rows.push_back('{mk(2, 5, 32'h8000_0000, 1'b0), CHK_PREDICT});
		dir_rows.push_back('{mk(7, 0, 32'h7FFF_FFFF, 1'b0), CHK_PREDICT});
		dir_rows.push_back('{mk(6, 6, -1, 1'b1), CHK_UNIT});
		dir_rows.push_back('{mk(0, 0, 32'h7FFF_FFFF, 1'b1), CHK_PREDICT});
		dir_rows.push_back('{mk(0, 0, 32'h8000_0000, 1'b1), CHK_ZERO_FAIL});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[n])
			send_beat(dir_rows[n].beat, dir_rows[n].chk);

		while (n_items < N_ITEMS) begin
			if ($urandom_range(0, 7) == 0) begin
				sender_burst   = $urandom_range(0, 1);
				receiver_burst = $urandom_range(0, 1);
			end
			if ($urandom_range(0, 9) < 7)
				send_good_matrix();
			else
				send_partial();
		end
		@(posedge clk);
		in_valid <= 1'b0;

		while (factor_q.size() != 0)
			@(posedge clk);
		tail = 0;
		while (tail < 200) begin
			@(posedge clk);
			tail++;
		end

		$display("Loaded %0d stored entries over %0d factorizations.",
			n_items, n_factorizations);
		$display("Checked %0d factor entries, %0d of them flagged not positive.",
			n_results, n_flagged);
		if (n_errors == 0)
			$display("cholesky_factor_6x6_top test passed");
		else
			$display("cholesky_factor_6x6_top test failed");
		$finish;
	end

endmodule
`default_nettype wire
